// ===== sv/smam_pkg.sv =====
package smam_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COORD_W       = 8;
  localparam int VAL_W         = 16;
  localparam int SUM_W         = 17;
  localparam int DIM_W         = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int MODE_W        = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLS = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic clear;
    logic step;
    logic finish;
  } smam_cmd_t;

  typedef struct packed {
    logic live;
  } smam_status_t;

endpackage

// ===== sv/smam_ctrl.sv =====
module smam_ctrl
  import smam_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MODE_W-1:0]   in_mode,
  input  smam_status_t        status,
  output smam_cmd_t           cmd,
  output logic                busy
);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_first  = (in_mode == MODE_LOAD_FIRST);
          cmd.load_second = (in_mode == MODE_LOAD_SECOND);
          if (in_mode == MODE_COMPUTE) begin
            cmd.clear = 1'b1;
            state_nxt = ST_MERGE;
          end
        end
      end
      ST_MERGE: begin
        if (status.live) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== sv/smam_dp.sv =====
module smam_dp
  import smam_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  smam_cmd_t                cmd,
  output smam_status_t             status,
  input  logic [COORD_W-1:0]       in_row,
  input  logic [COORD_W-1:0]       in_col,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  output logic                     out_strobe,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic signed [SUM_W-1:0]  out_sum_value,
  output logic                     out_entry_valid,
  output logic                     out_last,
  output logic                     out_size_mismatch
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  entry_t first_list_r  [MAX_TERMS];
  entry_t second_list_r [MAX_TERMS];

  logic [CNT_W-1:0] first_cnt_r, second_cnt_r;
  logic [CNT_W-1:0] a_r, b_r;
  logic [DIM_W-1:0] first_rows_r, first_cols_r, second_rows_r, second_cols_r;

  logic               have_last_r;
  logic [COORD_W-1:0] last_row_r, last_col_r;

  logic                    pend_vld_r;
  logic [COORD_W-1:0]      pend_row_r, pend_col_r;
  logic signed [SUM_W-1:0] pend_val_r;

  logic                    strobe_r, entry_valid_r, last_r, mismatch_r;
  logic [COORD_W-1:0]      row_r, col_r;
  logic signed [SUM_W-1:0] val_r;

  entry_t                  ea, eb;
  logic                    la, lb, eq, a_first;
  logic                    mismatch;
  logic [COORD_W-1:0]      new_row, new_col;
  logic signed [SUM_W-1:0] new_val;

  function automatic logic head_live(entry_t e, logic have_last,
                                     logic [COORD_W-1:0] lr, logic [COORD_W-1:0] lc,
                                     logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    logic in_area, after;
    in_area = ({1'b0, e.row} < rows) && ({1'b0, e.col} < cols);
    after   = !have_last || (e.row > lr) || ((e.row == lr) && (e.col > lc));
    return in_area && after;
  endfunction

  assign ea = first_list_r[a_r[IDX_W-1:0]];
  assign eb = second_list_r[b_r[IDX_W-1:0]];

  assign la = (a_r < first_cnt_r) &&
              head_live(ea, have_last_r, last_row_r, last_col_r, second_rows_r, second_cols_r);
  assign lb = (b_r < second_cnt_r) &&
              head_live(eb, have_last_r, last_row_r, last_col_r, second_rows_r, second_cols_r);
  assign eq = la && lb && (ea.row == eb.row) && (ea.col == eb.col);
  assign a_first = la && (!lb || (ea.row < eb.row) ||
                          ((ea.row == eb.row) && (ea.col < eb.col)));

  assign status.live = la || lb;
  assign mismatch = (first_rows_r != second_rows_r) || (first_cols_r != second_cols_r);

  always_comb begin
    if (eq) begin
      new_row = ea.row;
      new_col = ea.col;
      new_val = SUM_W'(ea.value) + SUM_W'(eb.value);
    end else if (a_first) begin
      new_row = ea.row;
      new_col = ea.col;
      new_val = SUM_W'(ea.value);
    end else begin
      new_row = eb.row;
      new_col = eb.col;
      new_val = SUM_W'(eb.value);
    end
  end

  // list storage
  always_ff @(posedge clk) begin
    if (cmd.load_first && (first_cnt_r < CNT_MAX)) begin
      first_list_r[first_cnt_r[IDX_W-1:0]] <= '{row: in_row, col: in_col, value: in_value};
    end
    if (cmd.load_second && (second_cnt_r < CNT_MAX)) begin
      second_list_r[second_cnt_r[IDX_W-1:0]] <= '{row: in_row, col: in_col, value: in_value};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r   <= '0;
      second_cnt_r  <= '0;
      a_r           <= '0;
      b_r           <= '0;
      have_last_r   <= 1'b0;
      pend_vld_r    <= 1'b0;
      strobe_r      <= 1'b0;
      first_rows_r  <= DIM_RESET;
      first_cols_r  <= DIM_RESET;
      second_rows_r <= DIM_RESET;
      second_cols_r <= DIM_RESET;
    end else begin
      strobe_r <= cmd.finish || (cmd.step && pend_vld_r);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST_ROWS:  first_rows_r  <= cfg_data;
          CFG_FIRST_COLS:  first_cols_r  <= cfg_data;
          CFG_SECOND_ROWS: second_rows_r <= cfg_data;
          CFG_SECOND_COLS: second_cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_first && (first_cnt_r < CNT_MAX)) begin
        first_cnt_r <= first_cnt_r + 1'b1;
      end
      if (cmd.load_second && (second_cnt_r < CNT_MAX)) begin
        second_cnt_r <= second_cnt_r + 1'b1;
      end
      if (cmd.clear) begin
        a_r         <= '0;
        b_r         <= '0;
        have_last_r <= 1'b0;
        pend_vld_r  <= 1'b0;
      end
      if (cmd.step) begin
        if (eq || a_first) a_r <= a_r + 1'b1;
        if (eq || !a_first) b_r <= b_r + 1'b1;
        have_last_r <= 1'b1;
        pend_vld_r  <= 1'b1;
      end
      if (cmd.finish) begin
        first_cnt_r  <= '0;
        second_cnt_r <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      last_row_r    <= new_row;
      last_col_r    <= new_col;
      pend_row_r    <= new_row;
      pend_col_r    <= new_col;
      pend_val_r    <= new_val;
      row_r         <= pend_row_r;
      col_r         <= pend_col_r;
      val_r         <= pend_val_r;
      entry_valid_r <= 1'b1;
      last_r        <= 1'b0;
      mismatch_r    <= mismatch;
    end else if (cmd.finish) begin
      row_r         <= pend_vld_r ? pend_row_r : '0;
      col_r         <= pend_vld_r ? pend_col_r : '0;
      val_r         <= pend_vld_r ? pend_val_r : '0;
      entry_valid_r <= pend_vld_r;
      last_r        <= 1'b1;
      mismatch_r    <= mismatch;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_sum_value     = val_r;
  assign out_entry_valid   = entry_valid_r;
  assign out_last          = last_r;
  assign out_size_mismatch = mismatch_r;

endmodule

// ===== sv/sparse_matrix_add_merge_unit.sv =====
// Loads leave busy low, so a load beat may follow every cycle.
// A compute beat keeps busy high until the merge ends, also when the sum is
// empty: the merge takes one step per cycle, consuming one or both heads.
// Results appear one per cycle, each passing the pending registers and then the
// output registers; the final one (out_last) arrives the cycle busy drops.
// The receiver cannot stall. Reset clears list counts and output strobe and sets
// all dimensions to 16.
module sparse_matrix_add_merge_unit
  import smam_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [COORD_W-1:0]       in_row,
  input  logic [COORD_W-1:0]       in_col,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  output logic                     out_strobe,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic signed [SUM_W-1:0]  out_sum_value,
  output logic                     out_entry_valid,
  output logic                     out_last,
  output logic                     out_size_mismatch
);

  smam_cmd_t    cmd;
  smam_status_t status;

  smam_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  smam_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_strobe        (out_strobe),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_sum_value     (out_sum_value),
    .out_entry_valid   (out_entry_valid),
    .out_last          (out_last),
    .out_size_mismatch (out_size_mismatch)
  );

`ifndef SYNTHESIS
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("final beat while still busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |-> out_last)
    else $error("empty result beat not marked last");

  a_beat_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a compute run");

  a_run_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe && out_last)
    else $error("compute run ended without final beat");
`endif

endmodule
